@@ sv/osdg_pkg.sv @@
package osdg_pkg;

  // Field widths
  localparam int COORD_W  = 8;
  localparam int CELL_W   = COORD_W + 2;
  localparam int ROW_W    = 16;
  localparam int ADDR_W   = 20;
  localparam int NARROW_W = 8;
  localparam int WIDE_W   = 16;

  // Operation codes
  localparam logic [1:0] OP_LOCATE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_EDGE  = 2'd1;
  localparam logic [1:0] REG_GBK   = 2'd2;

  // Pixel classes
  localparam logic [1:0] PIX_BG   = 2'd0;
  localparam logic [1:0] PIX_FORE = 2'd1;
  localparam logic [1:0] PIX_EDGE = 2'd2;

  // Character table layout
  localparam logic [7:0] DBL_LEAD     = 8'h80;
  localparam logic [7:0] GB_BASE      = 8'hA1;
  localparam logic [7:0] GB_COLS      = 8'd94;
  localparam logic [7:0] GBK_LEAD     = 8'h81;
  localparam logic [7:0] GBK_COLS     = 8'd190;
  localparam logic [7:0] GBK_GAP      = 8'h7F;
  localparam logic [7:0] GBK_TRAIL_LO = 8'h40;
  localparam logic [7:0] GBK_TRAIL_HI = 8'h41;
  localparam int         ASCII_SHIFT  = 4;   // 16 bytes per glyph
  localparam int         DBL_SHIFT    = 5;   // 32 bytes per glyph

  // Queue and divider sizing
  localparam int QDEPTH    = 2;
  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = COORD_W / DIV_BITS;

  typedef enum logic [2:0] {
    K_ASCII,
    K_DBL,
    K_BAD,
    K_LOAD,
    K_PIXEL
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         a;      // table row term, ASCII code or pix_x
    logic [7:0]         b;      // table column term or pix_y
    logic               gbk;
    logic [3:0]         ridx;
    logic [ROW_W-1:0]   bits;
    logic               nar;
  } item_t;

  typedef struct packed {
    logic [3:0] scale;
    logic       edge_en;
    logic       gbk;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] glyph_address;
    logic              double_byte;
    logic              code_invalid;
    logic [1:0]        pixel;
    logic              outside;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RD,
    S_PIX
  } back_state_t;

endpackage

@@ sv/osdg_ram.sv @@
module osdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/osdg_front.sv @@
module osdg_front (
  input  logic                        gbk_mode,
  input  logic [1:0]                  op,
  input  logic [7:0]                  lead_byte,
  input  logic [7:0]                  trail_byte,
  input  logic [3:0]                  row_index,
  input  logic [osdg_pkg::ROW_W-1:0]  row_bits,
  input  logic                        narrow,
  input  logic [7:0]                  pix_x,
  input  logic [7:0]                  pix_y,
  output logic                        keep,
  output osdg_pkg::item_t             item
);
  import osdg_pkg::*;

  // Classify the item and reduce a character code to table row/column terms.
  always_comb begin
    keep      = 1'b1;
    item.kind = K_ASCII;
    item.a    = lead_byte;
    item.b    = trail_byte;
    item.gbk  = gbk_mode;
    item.ridx = row_index;
    item.bits = row_bits;
    item.nar  = narrow;
    case (op)
      OP_LOCATE: begin
        if (lead_byte > DBL_LEAD) begin
          if (gbk_mode) begin
            if (trail_byte < GBK_TRAIL_LO) begin
              item.kind = K_BAD;
            end else begin
              item.kind = K_DBL;
              item.a    = lead_byte - GBK_LEAD;
              // skip the unused 0x7f column
              item.b    = (trail_byte < GBK_GAP) ? (trail_byte - GBK_TRAIL_LO)
                                                 : (trail_byte - GBK_TRAIL_HI);
            end
          end else begin
            if (lead_byte < GB_BASE || trail_byte < GB_BASE) begin
              item.kind = K_BAD;
            end else begin
              item.kind = K_DBL;
              item.a    = lead_byte - GB_BASE;
              item.b    = trail_byte - GB_BASE;
            end
          end
        end
      end
      OP_LOAD: begin
        item.kind = K_LOAD;
      end
      OP_PIXEL: begin
        item.kind = K_PIXEL;
        item.a    = pix_x;
        item.b    = pix_y;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/osdg_queue.sv @@
module osdg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  osdg_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output osdg_pkg::item_t dout,
  output logic            empty
);
  import osdg_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         slots [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> count == CW'($past(count) + 1'b1))
    else $error("queue count did not advance on push");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !push) |=> count == CW'($past(count) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

@@ sv/osdg_div.sv @@
module osdg_div #(
  parameter int DIV_W = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [osdg_pkg::COORD_W-1:0] dividend,
  input  logic [DIV_W-1:0]             divisor,
  output logic                         busy,
  output logic [osdg_pkg::COORD_W-1:0] quot,
  output logic [DIV_W-1:0]             rem
);
  import osdg_pkg::*;

  localparam int SC_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [COORD_W-1:0] sh;
  logic [DIV_W-1:0]   dsr;
  logic [SC_W-1:0]    cnt;
  logic [COORD_W-1:0] sh_next;
  logic [COORD_W-1:0] quot_next;
  logic [DIV_W-1:0]   rem_next;

  // Retire DIV_BITS quotient bits per cycle while busy, restoring form.
  always_comb begin
    logic [DIV_W:0] tmp;
    sh_next   = sh;
    quot_next = quot;
    rem_next  = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      tmp     = {rem_next, sh_next[COORD_W-1]};
      sh_next = {sh_next[COORD_W-2:0], 1'b0};
      if (tmp >= {1'b0, dsr}) begin
        tmp       = tmp - {1'b0, dsr};
        quot_next = {quot_next[COORD_W-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[COORD_W-2:0], 1'b0};
      end
      rem_next = tmp[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == SC_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= dividend;
      dsr  <= divisor;
      quot <= '0;
      rem  <= '0;
    end else if (busy) begin
      sh   <= sh_next;
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule

@@ sv/osdg_back.sv @@
module osdg_back #(
  parameter int GLYPH_ROWS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  osdg_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  osdg_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            pop,
  output logic            out_valid,
  output osdg_pkg::res_t  res
);
  import osdg_pkg::*;

  localparam int SW      = $clog2(MAX_SCALE + 1);
  localparam int AW      = $clog2(GLYPH_ROWS);
  localparam int DIM_MAX = ((GLYPH_ROWS > WIDE_W) ? GLYPH_ROWS : WIDE_W) * MAX_SCALE + 2;
  localparam int DIMW    = ($clog2(DIM_MAX + 1) > COORD_W) ? $clog2(DIM_MAX + 1) : COORD_W + 1;
  localparam logic [8:0] NEIGH_MASK = 9'b111101111;

  back_state_t        state;
  back_state_t        state_next;
  item_t              cur;
  logic               outside_q;
  logic               narrow_q;
  logic [1:0]         cnt;
  logic [ROW_W-1:0]   rowbuf [3];
  logic               res_load;
  res_t               res_next;
  logic               slot_free;

  logic [SW-1:0]      s;
  logic               border;
  logic [DIMW-1:0]    tw;
  logic [DIMW-1:0]    th;
  logic               off_glyph;

  logic               div_start;
  logic               div_busy;
  logic               div_busy_y;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [SW-1:0]      rx;
  logic [SW-1:0]      ry;

  logic [CELL_W-1:0]  rq [3];
  logic [CELL_W-1:0]  cq [3];
  logic               rok [3];
  logic               cok [3];
  logic [8:0]         hit;
  logic               fore;
  logic [1:0]         pix_class;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [ROW_W-1:0]   ram_rdata;

  logic [15:0]        prod;
  logic [15:0]        tidx;
  logic [ADDR_W-1:0]  loc_addr;

  // Cell offset of neighbor coordinate q*s + r + e, with e in -2..1.
  function automatic logic signed [2:0] cell_adj(input logic [SW-1:0] r,
                                                 input logic signed [2:0] e,
                                                 input logic [SW-1:0] sc);
    logic signed [SW+2:0] v;
    logic signed [SW+2:0] sv;
    v  = $signed({3'b000, r}) + $signed({{SW{e[2]}}, e});
    sv = $signed({3'b000, sc});
    if (v >= sv) begin
      return 3'sd1;
    end else if (v >= 0) begin
      return 3'sd0;
    end else if (v >= -sv) begin
      return -3'sd1;
    end else begin
      return -3'sd2;
    end
  endfunction

  always_comb begin
    if (cfg.scale == 4'd0) begin
      s = SW'(1);
    end else if (int'(cfg.scale) > MAX_SCALE) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = SW'(cfg.scale);
    end
  end

  assign border    = cfg.edge_en;
  assign tw        = (narrow_q ? (DIMW'(s) << 3) : (DIMW'(s) << 4)) + DIMW'({border, 1'b0});
  assign th        = DIMW'(GLYPH_ROWS * s) + DIMW'({border, 1'b0});
  assign off_glyph = (DIMW'(q_item.a) >= tw) || (DIMW'(q_item.b) >= th);
  assign slot_free = !out_valid || pop;

  // Neighbor rows and columns around the requested coordinate.
  always_comb begin
    logic signed [2:0] e;
    logic signed [2:0] ay;
    logic signed [2:0] ax;
    for (int k = 0; k < 3; k++) begin
      e      = 3'(k - 1) - {2'b00, border};
      ay     = cell_adj(ry, e, s);
      ax     = cell_adj(rx, e, s);
      rq[k]  = {2'b00, qy} + {{(CELL_W-3){ay[2]}}, ay};
      cq[k]  = {2'b00, qx} + {{(CELL_W-3){ax[2]}}, ax};
      rok[k] = !rq[k][CELL_W-1] && (rq[k] < CELL_W'(GLYPH_ROWS));
      cok[k] = !cq[k][CELL_W-1] &&
               (cq[k] < (narrow_q ? CELL_W'(NARROW_W) : CELL_W'(WIDE_W)));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        hit[k*3 + j] = cok[j] && rowbuf[k][~cq[j][3:0]];
      end
    end
    fore = hit[4];
    if (fore) begin
      pix_class = PIX_FORE;
    end else if (border && |(hit & NEIGH_MASK)) begin
      pix_class = PIX_EDGE;
    end else begin
      pix_class = PIX_BG;
    end
  end

  always_comb begin
    case (cnt)
      2'd0:    ram_raddr = rq[0][AW-1:0];
      2'd1:    ram_raddr = rq[1][AW-1:0];
      default: ram_raddr = rq[2][AW-1:0];
    endcase
  end

  assign prod = 16'(cur.a) * 16'(cur.gbk ? GBK_COLS : GB_COLS);
  assign tidx = prod + 16'(cur.b);

  always_comb begin
    case (cur.kind)
      K_DBL:   loc_addr = ADDR_W'(tidx) << DBL_SHIFT;
      K_ASCII: loc_addr = ADDR_W'(cur.a) << ASCII_SHIFT;
      default: loc_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_item.kind)
            K_LOAD: begin
              ram_we = (int'(q_item.ridx) < GLYPH_ROWS);
            end
            K_PIXEL: begin
              if (off_glyph) begin
                state_next = S_PIX;
              end else begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end
            end
            default: begin
              state_next = S_MUL;
            end
          endcase
        end
      end
      S_MUL: begin
        if (slot_free) begin
          res_load              = 1'b1;
          res_next.glyph_address = loc_addr;
          res_next.double_byte  = (cur.kind != K_ASCII);
          res_next.code_invalid = (cur.kind == K_BAD);
          state_next            = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (cnt == 2'd3) begin
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        if (slot_free) begin
          res_load         = 1'b1;
          res_next.outside = outside_q;
          res_next.pixel   = outside_q ? PIX_BG : pix_class;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_item.kind == K_LOAD) begin
        narrow_q <= q_item.nar;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_item;
      outside_q <= off_glyph;
    end
    if (state == S_DIV) begin
      cnt <= 2'd0;
    end else if (state == S_RD) begin
      cnt <= cnt + 2'd1;
    end
    if (state == S_RD && cnt != 2'd0) begin
      rowbuf[2'(cnt - 2'd1)] <= rok[2'(cnt - 2'd1)] ? ram_rdata : '0;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // The dividers load on the dequeue edge, so take the coordinates from the queue head.
  osdg_div #(.DIV_W(SW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_item.a),
    .divisor  (s),
    .busy     (div_busy),
    .quot     (qx),
    .rem      (rx)
  );

  osdg_div #(.DIV_W(SW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_item.b),
    .divisor  (s),
    .busy     (div_busy_y),
    .quot     (qy),
    .rem      (ry)
  );

  osdg_ram #(.WIDTH(ROW_W), .DEPTH(GLYPH_ROWS)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_item.ridx)),
    .wdata (q_item.bits),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || pop))
    else $error("result register overwritten");

  a_div_to_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !div_busy) |=> state == S_RD)
    else $error("divider finished but row reads did not start");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    div_busy == div_busy_y)
    else $error("coordinate dividers out of step");

endmodule

@@ sv/osd_glyph_scale_outline.sv @@
// On-screen-display glyph engine. Push an item with op 0 to turn a character code
// into its font-memory byte offset (ASCII at code*16; a lead byte above 0x80 gives a
// 32-byte GB2312 or GBK glyph, per gbk_mode; a byte below the table base returns
// code_invalid with address zero), op 1 to load one 16-bit glyph row plus the narrow
// flag (no result), and op 2 to read one pixel of the loaded glyph magnified by scale
// and optionally ringed by a one-pixel edge. Op 3 is dropped. Results leave in order
// through a one-entry result register. A load is written on dequeue; a locate is
// dequeued, then its address formed; an on-glyph pixel is dequeued, divided by the
// 2-bit-per-cycle coordinate dividers, reads three neighbor rows through the single
// read port of the glyph row RAM and is classified. A two-entry queue lets new items
// come in while the back end works. Glyph rows come up undefined; load every row
// before reading pixels. Write configuration only while the block is idle.
module osd_glyph_scale_outline #(
  parameter int GLYPH_ROWS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        op,
  input  logic [7:0]                        lead_byte,
  input  logic [7:0]                        trail_byte,
  input  logic [3:0]                        row_index,
  input  logic [osdg_pkg::ROW_W-1:0]        row_bits,
  input  logic                              narrow,
  input  logic [7:0]                        pix_x,
  input  logic [7:0]                        pix_y,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [osdg_pkg::ADDR_W-1:0]       glyph_address,
  output logic                              double_byte,
  output logic                              code_invalid,
  output logic [1:0]                        pixel,
  output logic                              outside,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [3:0]                        cfg_data
);
  import osdg_pkg::*;

  cfg_t  cfg;
  item_t f_item;
  item_t q_item;
  logic  f_keep;
  logic  q_empty;
  logic  q_pop;
  logic  out_valid;
  res_t  res;

  // Always take configuration writes; drop writes to unknown indexes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale   <= 4'd1;
      cfg.edge_en <= 1'b0;
      cfg.gbk     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE: cfg.scale   <= cfg_data;
        REG_EDGE:  cfg.edge_en <= cfg_data[0];
        REG_GBK:   cfg.gbk     <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // Front: decode the op and reduce the character code.
  osdg_front u_front (
    .gbk_mode   (cfg.gbk),
    .op         (op),
    .lead_byte  (lead_byte),
    .trail_byte (trail_byte),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .narrow     (narrow),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .keep       (f_keep),
    .item       (f_item)
  );

  // Hold classified items until the back end is free; op 3 never enters.
  osdg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && f_keep),
    .din   (f_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  // Back: glyph store, address multiply, scaled pixel lookup, result register.
  osdg_back #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign empty         = !out_valid;
  assign glyph_address = res.glyph_address;
  assign double_byte   = res.double_byte;
  assign code_invalid  = res.code_invalid;
  assign pixel         = res.pixel;
  assign outside       = res.outside;

endmodule
